FILE: design/idtbs_pkg.sv
// Package: shared types and constants for the key/link table search block.
`timescale 1ns / 1ps
package idtbs_pkg;

    localparam logic [1:0] FUNC_WR_KEY  = 2'd0;
    localparam logic [1:0] FUNC_WR_LINK = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP  = 2'd2;

    localparam logic REG_KEY_COUNT  = 1'b0;
    localparam logic REG_LINK_COUNT = 1'b1;

    localparam int          COUNT_W       = 11;
    localparam int          POS_W         = 10;
    localparam int          KEY_POS_SPAN  = 1024;
    localparam logic [7:0]  VERSION_MASK  = 8'hFF;
    localparam logic [7:0]  VERSION_THREE = 8'h03;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic [1:0]  func;
        logic [9:0]  entry_index;
        logic [31:0] key_high;
        logic [31:0] key_low;
        logic [7:0]  owner_id;
        logic [9:0]  linked_key_index;
    } t_item;

    typedef struct packed {
        logic       key_found;
        logic [9:0] key_position;
        logic       link_found;
        logic [9:0] link_position;
        logic       version_three;
    } t_result;

endpackage

FILE: design/idtbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module idtbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/id_table_binary_search_link_top.sv
// Top level: sorted key table binary search followed by a linear link table scan.
//
// Usage:
//   Items enter on i_item when start is high and busy is low. Key and link
//   writes give no result. A lookup binary-searches the first key_count
//   key entries, then on a hit scans the first link_count link entries for
//   the first (owner, key index) match. Each probe issues the key RAM read
//   in ST_PROBE, then does a 64-bit compare in ST_CMP, and the scan reads
//   one link entry per cycle. A lookup keeps busy high until its result shows.
//   The result beat shows on o_result for one cycle with o_result_valid; the
//   next item may be accepted in that same cycle. The receiver cannot stall.
//   Config: APB, key_count at 0x0, link_count at 0x4, written while idle.
//   Reset (synchronous, active low) clears the sequencer and both counts;
//   table contents are undefined until written.
`timescale 1ns / 1ps
module id_table_binary_search_link_top #(
    parameter int KEY_DEPTH  = 1024,
    parameter int LINK_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  idtbs_pkg::t_item   i_item,
    output logic               o_result_valid,
    output idtbs_pkg::t_result o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int KAW = $clog2(KEY_DEPTH);
    localparam int LAW = $clog2(LINK_DEPTH);
    localparam int KCW = $clog2(KEY_DEPTH + 1);
    localparam int LCW = $clog2(LINK_DEPTH + 1);
    localparam int LINK_W = 18;

    idtbs_pkg::t_state  r_state, n_state;
    logic [KCW-1:0]     r_lo, n_lo;
    logic [KCW-1:0]     r_hi, n_hi;
    logic [KCW-1:0]     r_mid, n_mid;
    logic [63:0]        r_key, n_key;
    logic [7:0]         r_owner, n_owner;
    logic               r_ver, n_ver;
    logic [LCW-1:0]     r_issue, n_issue;
    logic [LCW-1:0]     r_lnk_n, n_lnk_n;
    logic [LAW-1:0]     r_chk, n_chk;
    logic               r_rd_vld, n_rd_vld;
    idtbs_pkg::t_result r_res, n_res;
    logic               r_res_vld, n_res_vld;
    logic [idtbs_pkg::COUNT_W-1:0] r_key_count;
    logic [idtbs_pkg::COUNT_W-1:0] r_link_count;

    logic               accept;
    logic               cfg_wr;
    logic [KCW:0]       mid_sum;
    logic [KCW-1:0]     mid;
    logic               key_we, link_we;
    logic               key_re, link_re;
    logic [KAW-1:0]     key_raddr;
    logic [LAW-1:0]     link_raddr;
    logic [63:0]        key_rdata;
    logic [LINK_W-1:0]  link_rdata;
    logic               issue_ok;
    logic               link_hit;

    assign accept  = start && !busy;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == idtbs_pkg::REG_LINK_COUNT) ? 32'(r_link_count)
                                                             : 32'(r_key_count);

    assign mid_sum  = (KCW+1)'(r_lo) + (KCW+1)'(r_hi) - (KCW+1)'(1);
    assign mid      = mid_sum[KCW:1];
    assign issue_ok = r_issue < r_lnk_n;
    assign link_hit = r_rd_vld && (link_rdata == {r_owner, idtbs_pkg::POS_W'(r_mid)});

    assign key_we  = accept && (i_item.func == idtbs_pkg::FUNC_WR_KEY)
                     && (32'(i_item.entry_index) < 32'(KEY_DEPTH));
    assign link_we = accept && (i_item.func == idtbs_pkg::FUNC_WR_LINK)
                     && (32'(i_item.entry_index) < 32'(LINK_DEPTH));

    idtbs_ram #(.WIDTH(64), .DEPTH(KEY_DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (KAW'(i_item.entry_index)),
        .i_wdata ({i_item.key_high, i_item.key_low}),
        .i_re    (key_re),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    idtbs_ram #(.WIDTH(LINK_W), .DEPTH(LINK_DEPTH)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (LAW'(i_item.entry_index)),
        .i_wdata ({i_item.owner_id, i_item.linked_key_index}),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    // next state and datapath
    always_comb begin
        n_state   = r_state;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_key     = r_key;
        n_owner   = r_owner;
        n_ver     = r_ver;
        n_issue   = r_issue;
        n_lnk_n   = r_lnk_n;
        n_chk     = r_chk;
        n_rd_vld  = 1'b0;
        n_res     = r_res;
        n_res_vld = 1'b0;
        case (r_state)
            idtbs_pkg::ST_IDLE: begin
                if (accept && (i_item.func == idtbs_pkg::FUNC_LOOKUP)) begin
                    n_state = idtbs_pkg::ST_PROBE;
                    n_lo    = '0;
                    n_hi    = (32'(r_key_count) > 32'(KEY_DEPTH)) ? KCW'(KEY_DEPTH)
                                                                  : KCW'(r_key_count);
                    n_lnk_n = (32'(r_link_count) > 32'(LINK_DEPTH)) ? LCW'(LINK_DEPTH)
                                                                    : LCW'(r_link_count);
                    n_key   = {i_item.key_high, i_item.key_low};
                    n_owner = i_item.owner_id;
                    n_ver   = (i_item.key_low[7:0] & idtbs_pkg::VERSION_MASK)
                              == idtbs_pkg::VERSION_THREE;
                end
            end
            idtbs_pkg::ST_PROBE: begin
                if (r_lo < r_hi) begin
                    n_mid   = mid;
                    n_state = idtbs_pkg::ST_CMP;
                end else begin
                    n_state   = idtbs_pkg::ST_IDLE;
                    n_res     = '{key_found: 1'b0, key_position: '0, link_found: 1'b0,
                                  link_position: '0, version_three: r_ver};
                    n_res_vld = 1'b1;
                end
            end
            idtbs_pkg::ST_CMP: begin
                if (key_rdata < r_key) begin
                    n_lo    = r_mid + KCW'(1);
                    n_state = idtbs_pkg::ST_PROBE;
                end else if (key_rdata > r_key) begin
                    n_hi    = r_mid;
                    n_state = idtbs_pkg::ST_PROBE;
                end else if ((32'(r_mid) < 32'(idtbs_pkg::KEY_POS_SPAN)) &&
                             (r_lnk_n != '0)) begin
                    n_state = idtbs_pkg::ST_SCAN;
                    n_issue = '0;
                end else begin
                    n_state   = idtbs_pkg::ST_IDLE;
                    n_res     = '{key_found: 1'b1,
                                  key_position: idtbs_pkg::POS_W'(r_mid),
                                  link_found: 1'b0, link_position: '0,
                                  version_three: r_ver};
                    n_res_vld = 1'b1;
                end
            end
            idtbs_pkg::ST_SCAN: begin
                if (link_hit || !issue_ok) begin
                    n_state   = idtbs_pkg::ST_IDLE;
                    n_res     = '{key_found: 1'b1,
                                  key_position: idtbs_pkg::POS_W'(r_mid),
                                  link_found: link_hit,
                                  link_position: link_hit ? idtbs_pkg::POS_W'(r_chk) : '0,
                                  version_three: r_ver};
                    n_res_vld = 1'b1;
                end else begin
                    n_issue  = r_issue + LCW'(1);
                    n_chk    = r_issue[LAW-1:0];
                    n_rd_vld = 1'b1;
                end
            end
            default: begin
                n_state = idtbs_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and RAM read control
    always_comb begin
        busy       = 1'b1;
        key_re     = 1'b0;
        key_raddr  = mid[KAW-1:0];
        link_re    = 1'b0;
        link_raddr = r_issue[LAW-1:0];
        case (r_state)
            idtbs_pkg::ST_IDLE: begin
                busy = 1'b0;
            end
            idtbs_pkg::ST_PROBE: begin
                key_re = r_lo < r_hi;
            end
            idtbs_pkg::ST_SCAN: begin
                link_re = issue_ok && !link_hit;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= idtbs_pkg::ST_IDLE;
            r_res_vld    <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_key_count  <= '0;
            r_link_count <= '0;
        end else begin
            r_state   <= n_state;
            r_res_vld <= n_res_vld;
            r_rd_vld  <= n_rd_vld;
            if (cfg_wr) begin
                if (paddr[2] == idtbs_pkg::REG_KEY_COUNT) begin
                    r_key_count <= pwdata[idtbs_pkg::COUNT_W-1:0];
                end else begin
                    r_link_count <= pwdata[idtbs_pkg::COUNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_key   <= n_key;
        r_owner <= n_owner;
        r_ver   <= n_ver;
        r_issue <= n_issue;
        r_lnk_n <= n_lnk_n;
        r_chk   <= n_chk;
        r_res   <= n_res;
    end

    assign o_result_valid = r_res_vld;
    assign o_result       = r_res;

    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result beat longer than one cycle");

    a_link_needs_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.link_found) |-> o_result.key_found)
        else $error("link hit without key hit");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.key_found) |->
        (o_result.key_position == '0 && o_result.link_position == '0))
        else $error("miss with nonzero position");

    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.func == idtbs_pkg::FUNC_LOOKUP) |=>
        (busy && !o_result_valid))
        else $error("lookup did not start search");

endmodule

FILE: dv/tb_id_table_binary_search_link_top.sv
// Testbench: loads both tables, runs directed and random lookups and checks every result beat.
`timescale 1ns / 1ps
module tb_id_table_binary_search_link_top;
    import idtbs_pkg::*;

    localparam int         TABLE_DEPTH = 1024;
    localparam int         PHASE_ITEMS = 70;
    localparam int         CYCLE_LIMIT = 2_000_000;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_item       i_item;
    logic        o_result_valid;
    t_result     o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int gap_pct;
    int cycle_count;

    class search_scoreboard;
        logic [63:0]        keys [TABLE_DEPTH];
        logic [17:0]        links [TABLE_DEPTH];
        logic [COUNT_W-1:0] key_count;
        logic [COUNT_W-1:0] link_count;
        t_result            expected_q[$];
        int                 errors;

        function new();
            key_count  = '0;
            link_count = '0;
            errors     = 0;
        endfunction

        function int used(logic [COUNT_W-1:0] c);
            return (c > TABLE_DEPTH) ? TABLE_DEPTH : int'(c);
        endfunction

        function void set_count(logic reg_sel, logic [COUNT_W-1:0] value);
            if (reg_sel == REG_KEY_COUNT) key_count = value;
            else link_count = value;
        endfunction

        function t_result search_tables(t_item it);
            t_result     r;
            int          lo;
            int          hi;
            int          mid;
            int          n;
            logic [63:0] key;
            r   = '0;
            key = {it.key_high, it.key_low};
            lo  = 0;
            hi  = used(key_count) - 1;
            while (lo <= hi && !r.key_found) begin
                mid = (lo + hi) / 2;
                if (keys[mid] < key) lo = mid + 1;
                else if (keys[mid] == key) begin
                    r.key_found    = 1'b1;
                    r.key_position = 10'(mid);
                end else hi = mid - 1;
            end
            if (r.key_found) begin
                n = used(link_count);
                for (int i = 0; i < n && !r.link_found; i++) begin
                    if (links[i] == {it.owner_id, r.key_position}) begin
                        r.link_found    = 1'b1;
                        r.link_position = 10'(i);
                    end
                end
            end
            r.version_three = (it.key_low[7:0] & VERSION_MASK) == VERSION_THREE;
            return r;
        endfunction

        function void note_item(t_item it);
            case (it.func)
                FUNC_WR_KEY:  keys[it.entry_index] = {it.key_high, it.key_low};
                FUNC_WR_LINK: links[it.entry_index] = {it.owner_id, it.linked_key_index};
                FUNC_LOOKUP:  expected_q.push_back(search_tables(it));
                default: ;
            endcase
        endfunction

        function void flag(string field, logic [9:0] want, logic [9:0] got);
            errors++;
            if (errors <= 40)
                $display("%0t: %s expected %0h got %0h", $time, field, want, got);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: result beat with no lookup pending, expected none got %h",
                             $time, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.key_found !== want.key_found)
                flag("key_found", 10'(want.key_found), 10'(got.key_found));
            if (got.key_position !== want.key_position)
                flag("key_position", want.key_position, got.key_position);
            if (got.link_found !== want.link_found)
                flag("link_found", 10'(want.link_found), 10'(got.link_found));
            if (got.link_position !== want.link_position)
                flag("link_position", want.link_position, got.link_position);
            if (got.version_three !== want.version_three)
                flag("version_three", 10'(want.version_three), 10'(got.version_three));
        endfunction
    endclass

    search_scoreboard board;

    id_table_binary_search_link_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) board.check_result(o_result);
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_id_table_binary_search_link_top NOT OK");
        $finish;
    end

    function automatic t_item random_item();
        t_item it;
        it.func             = 2'($urandom);
        it.entry_index      = 10'($urandom);
        it.key_high         = $urandom;
        it.key_low          = $urandom;
        it.owner_id         = 8'($urandom);
        it.linked_key_index = 10'($urandom);
        return it;
    endfunction

    function automatic t_item key_write(int idx, logic [63:0] value);
        t_item it;
        it                       = random_item();
        it.func                  = FUNC_WR_KEY;
        it.entry_index           = 10'(idx);
        {it.key_high, it.key_low} = value;
        return it;
    endfunction

    function automatic t_item link_write(int idx, logic [7:0] owner, int kidx);
        t_item it;
        it                  = random_item();
        it.func             = FUNC_WR_LINK;
        it.entry_index      = 10'(idx);
        it.owner_id         = owner;
        it.linked_key_index = 10'(kidx);
        return it;
    endfunction

    function automatic t_item lookup_item(logic [63:0] key, logic [7:0] owner);
        t_item it;
        it                        = random_item();
        it.func                   = FUNC_LOOKUP;
        {it.key_high, it.key_low} = key;
        it.owner_id               = owner;
        return it;
    endfunction

    function automatic logic [7:0] pick_owner();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    endfunction

    task automatic send_item(input t_item it);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_item(it);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_count(input logic reg_sel, input logic [COUNT_W-1:0] value);
        logic [20:0] junk;
        junk = 21'($urandom);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {junk, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_count(reg_sel, value);
    endtask

    task automatic random_step();
        int          kc;
        int          lc;
        int          sel;
        int          pick;
        int          j;
        logic [17:0] lnk;
        logic [63:0] key;
        logic [7:0]  owner;
        t_item       it;
        kc  = board.used(board.key_count);
        lc  = board.used(board.link_count);
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
            pick  = $urandom_range(0, 99);
            owner = pick_owner();
            if (pick < 50 && lc > 0) begin
                lnk   = board.links[$urandom_range(0, lc - 1)];
                key   = board.keys[lnk[9:0]];
                owner = lnk[17:10];
            end else if (pick < 80 && kc > 0) begin
                key = board.keys[$urandom_range(0, kc - 1)];
            end else if (pick < 90) begin
                key = board.keys[$urandom_range(0, TABLE_DEPTH - 1)] + 64'd1;
            end else begin
                key = {$urandom, $urandom};
            end
            send_item(lookup_item(key, owner));
        end else if (sel < 75) begin
            // neighbor copies keep the table sorted; a few random values break it
            j    = $urandom_range(0, TABLE_DEPTH - 1);
            pick = $urandom_range(0, 9);
            if (pick < 3 && j > 0) key = board.keys[j - 1];
            else if (pick < 6 && j < TABLE_DEPTH - 1) key = board.keys[j + 1];
            else if (pick < 8) key = board.keys[j];
            else key = {$urandom, $urandom};
            send_item(key_write(j, key));
        end else if (sel < 95) begin
            j = ($urandom_range(0, 1) == 0 && kc > 0) ? $urandom_range(0, kc - 1)
                                                      : $urandom_range(0, TABLE_DEPTH - 1);
            send_item(link_write($urandom_range(0, TABLE_DEPTH - 1), pick_owner(), j));
        end else begin
            it      = random_item();
            it.func = FUNC_UNUSED;
            send_item(it);
        end
    endtask

    initial begin
        logic [COUNT_W-1:0] kc;
        logic [COUNT_W-1:0] lc;
        logic [55:0]        upper;
        logic [63:0]        value;
        logic [63:0]        prev;
        t_item              it;

        board   = new();
        gap_pct = 0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table: no probes, nothing read
        send_item(lookup_item('0, 8'd0));
        send_item(lookup_item('1, 8'hFF));
        send_item(lookup_item({32'h8000_0000, 24'h0, VERSION_THREE}, 8'd1));
        it      = random_item();
        it.func = FUNC_UNUSED;
        it      = it | {$bits(t_item){1'b1}};
        send_item(it);

        // load sorted keys (with duplicates) and the link table
        gap_pct = 10;
        upper   = '0;
        prev    = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (i == 0) value = '0;
            else if (i == TABLE_DEPTH - 1) value = '1;
            else if ($urandom_range(0, 15) == 0) value = prev;
            else begin
                upper = upper + 56'({$urandom, $urandom} >> 18) + 56'd1;
                value = {upper, ($urandom_range(0, 3) == 0) ? VERSION_THREE : 8'($urandom)};
            end
            send_item(key_write(i, value));
            prev = value;
        end
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (i == 0) send_item(link_write(i, 8'd0, 0));
            else if (i == TABLE_DEPTH - 1) send_item(link_write(i, 8'hFF, TABLE_DEPTH - 1));
            else send_item(link_write(i, pick_owner(), $urandom_range(0, TABLE_DEPTH - 1)));
        end

        drain_results();
        write_count(REG_KEY_COUNT, 11'd1);
        write_count(REG_LINK_COUNT, 11'd1);
        send_item(lookup_item(board.keys[0], 8'd0));
        send_item(lookup_item(board.keys[1], 8'd0));

        drain_results();
        write_count(REG_KEY_COUNT, 11'd2047);
        write_count(REG_LINK_COUNT, 11'd2047);
        send_item(lookup_item('1, 8'hFF));
        send_item(lookup_item(board.keys[0], 8'd0));
        send_item(lookup_item(board.keys[511], 8'($urandom)));
        send_item(lookup_item(board.keys[300] + 64'd1, 8'd3));
        send_item(lookup_item({32'hFFFF_FFFF, 32'hFFFF_FFFE}, 8'd0));
        // out-of-order key, then restore order
        send_item(key_write(5, {32'hFFFF_FFFF, 24'h0, VERSION_THREE}));
        send_item(lookup_item({32'hFFFF_FFFF, 24'h0, VERSION_THREE}, 8'd0));
        send_item(key_write(5, board.keys[4]));
        // owner zero link, then a duplicated link pair
        send_item(link_write(2, 8'd0, 4));
        send_item(lookup_item(board.keys[4], 8'd0));
        send_item(link_write(10, 8'd7, 600));
        send_item(link_write(20, 8'd7, 600));
        send_item(lookup_item(board.keys[600], 8'd7));

        drain_results();
        write_count(REG_KEY_COUNT, 11'd1024);
        write_count(REG_LINK_COUNT, 11'd0);
        send_item(lookup_item(board.keys[100], board.links[0][17:10]));

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin kc = 11'd1024; lc = 11'd1024; gap_pct = 25; end
                1: begin kc = 11'd2047; lc = 11'd64;   gap_pct = 0;  end
                2: begin kc = 11'd1023; lc = 11'd1;    gap_pct = 50; end
                3: begin kc = 11'd0;    lc = 11'd5;    gap_pct = 25; end
                4: begin kc = 11'd1;    lc = 11'd1024; gap_pct = 25; end
                5: begin
                    kc      = 11'($urandom_range(2, 1024));
                    lc      = 11'($urandom_range(0, 200));
                    gap_pct = 50;
                end
                6: begin
                    kc      = 11'($urandom_range(0, 2047));
                    lc      = 11'($urandom_range(0, 2047));
                    gap_pct = 25;
                end
                default: begin
                    kc      = 11'($urandom_range(512, 1024));
                    lc      = 11'($urandom_range(0, 100));
                    gap_pct = 0;
                end
            endcase
            drain_results();
            write_count(REG_KEY_COUNT, kc);
            write_count(REG_LINK_COUNT, lc);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 99) == 0) drain_results();
                random_step();
            end
        end

        start <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("tb_id_table_binary_search_link_top OK");
        end else begin
            $display("tb_id_table_binary_search_link_top NOT OK");
        end
        $finish;
    end

endmodule
